// File: rtl/dflr_pkg.sv
// Shared types and constants for the dollar-framed line receiver.
// Used by dflr_line_mem and dollar_framed_line_receiver_unit; no dependencies.
`default_nettype none

package dflr_pkg;

  localparam int LINE_CAPACITY = 64;
  localparam int ADDR_W        = $clog2(LINE_CAPACITY);
  localparam int COUNT_W       = $clog2(LINE_CAPACITY + 1);

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_Z  = 8'h7A;

  typedef enum logic [1:0] {
    ACT_RECV  = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_READ  = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    PH_HUNT  = 2'd0,
    PH_LINE  = 2'd1,
    PH_READY = 2'd2
  } phase_t;

  typedef enum logic [3:0] {
    ST_IGNORED  = 4'd0,
    ST_START    = 4'd1,
    ST_RESTART  = 4'd2,
    ST_STORED   = 4'd3,
    ST_ERASED   = 4'd4,
    ST_FULL     = 4'd5,
    ST_COMPLETE = 4'd6,
    ST_REFUSED  = 4'd7,
    ST_CLEARED  = 4'd8,
    ST_READ     = 4'd9
  } status_t;

endpackage

`default_nettype wire

// File: rtl/dflr_line_mem.sv
// Character store of the line receiver: one write port, one registered read port.
// Depends on dflr_pkg for the depth and address width.
`default_nettype none

module dflr_line_mem
  import dflr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [7:0]        wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [7:0]        rd_data
);

  logic [7:0] mem [LINE_CAPACITY];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // The read data holds between reads so that a stalled result keeps its character.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/dollar_framed_line_receiver_unit.sv
// Top level of the dollar-framed line receiver.
// Depends on dflr_pkg and dflr_line_mem.
`default_nettype none

// Assembles one command line from a byte stream: a line opens at '$', closes at CR or LF,
// and backspace removes the last character. Lower-case letters are stored upper-cased, up
// to 64 characters; further bytes are dropped. Once complete the line is held and bytes are
// refused until a clear item. A read item returns the character at an index, or zero at or
// past the length. Each input transfer yields exactly one result transfer. One item is
// accepted every cycle when not stalled: the line state updates and the store is written
// or read in the accepting cycle, and the result appears in the output register on the next
// cycle. Input is taken whenever the output register is empty or is being emptied in the same cycle.

module dollar_framed_line_receiver_unit
  import dflr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,  // byte_in [7:0], read_index [13:8], zeros [15:14]
  input  wire logic [1:0]  s_tuser,  // action [1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [15:0] m_tdata,  // line_length [6:0], line_ready [7], read_char [15:8]
  output logic      [3:0]  m_tuser   // status [3:0]
);

  phase_t             phase, phase_next;
  logic [COUNT_W-1:0] write_count, write_count_next;

  status_t            status, status_next;
  logic [COUNT_W-1:0] line_length;
  logic               line_ready;
  logic               read_hit, read_hit_next;
  logic               out_valid;

  logic               accept;
  action_t            action;
  logic [7:0]         byte_in;
  logic [5:0]         read_index;
  logic [7:0]         stored_byte;
  logic               store_wr;
  logic [7:0]         mem_q;

  assign action     = action_t'(s_tuser);
  assign byte_in    = s_tdata[7:0];
  assign read_index = s_tdata[13:8];

  assign s_tready = !out_valid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // Only ASCII a-z is folded to upper case.
  assign stored_byte = (byte_in >= CH_LOW_A && byte_in <= CH_LOW_Z) ?
                       (byte_in & 8'hDF) : byte_in;

  // Next line state.
  always_comb begin
    phase_next       = phase;
    write_count_next = write_count;
    unique case (action)
      ACT_RECV: begin
        unique case (phase)
          PH_HUNT: begin
            if (byte_in == CH_DOLLAR) begin
              phase_next = PH_LINE;
            end
          end
          PH_LINE: begin
            if (byte_in == CH_DOLLAR) begin
              write_count_next = '0;
            end else if (byte_in == CH_CR || byte_in == CH_LF) begin
              phase_next = PH_READY;
            end else if (byte_in == CH_BS) begin
              if (write_count != '0) begin
                write_count_next = write_count - COUNT_W'(1);
              end
            end else if (write_count < COUNT_W'(LINE_CAPACITY)) begin
              write_count_next = write_count + COUNT_W'(1);
            end
          end
          default: begin
          end
        endcase
      end
      ACT_CLEAR: begin
        phase_next       = PH_HUNT;
        write_count_next = '0;
      end
      default: begin
      end
    endcase
  end

  // Status code, store write and read qualification for the item.
  always_comb begin
    status_next   = ST_IGNORED;
    store_wr      = 1'b0;
    read_hit_next = 1'b0;
    unique case (action)
      ACT_RECV: begin
        unique case (phase)
          PH_HUNT: begin
            if (byte_in == CH_DOLLAR) begin
              status_next = ST_START;
            end
          end
          PH_LINE: begin
            if (byte_in == CH_DOLLAR) begin
              status_next = ST_RESTART;
            end else if (byte_in == CH_CR || byte_in == CH_LF) begin
              status_next = ST_COMPLETE;
            end else if (byte_in == CH_BS) begin
              status_next = (write_count != '0) ? ST_ERASED : ST_IGNORED;
            end else if (write_count < COUNT_W'(LINE_CAPACITY)) begin
              status_next = ST_STORED;
              store_wr    = 1'b1;
            end else begin
              status_next = ST_FULL;
            end
          end
          default: begin
            status_next = ST_REFUSED;
          end
        endcase
      end
      ACT_CLEAR: begin
        status_next = ST_CLEARED;
      end
      ACT_READ: begin
        status_next   = ST_READ;
        read_hit_next = (COUNT_W'(read_index) < write_count);
      end
      default: begin
      end
    endcase
  end

  dflr_line_mem u_line_mem (
    .clk     (clk),
    .wr_en   (accept && store_wr),
    .wr_addr (write_count[ADDR_W-1:0]),
    .wr_data (stored_byte),
    .rd_en   (accept && action == ACT_READ),
    .rd_addr (read_index[ADDR_W-1:0]),
    .rd_data (mem_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HUNT;
      write_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (accept) begin
        phase       <= phase_next;
        write_count <= write_count_next;
        out_valid   <= 1'b1;
      end else if (m_tready) begin
        out_valid   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status      <= status_next;
      line_length <= write_count_next;
      line_ready  <= (phase_next == PH_READY);
      read_hit    <= read_hit_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = status;
  assign m_tdata  = {(read_hit ? mem_q : 8'h00), line_ready, line_length};

endmodule

`default_nettype wire

// File: tb/sv/dflr_checker.sv
`timescale 1ns / 100ps
// Result checker for the dollar-framed line receiver: it watches both stream channels,
// predicts each result from the accepted inputs and compares them field by field.
// Depends on dflr_pkg.

module dflr_checker
  import dflr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,  // byte_in [7:0], read_index [13:8], zeros [15:14]
  input  logic [1:0]  s_tuser,  // action [1:0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,  // line_length [6:0], line_ready [7], read_char [15:8]
  input  logic [3:0]  m_tuser,  // status [3:0]
  output int          errors,
  output int          pending
);

  localparam logic [7:0] CASE_OFFSET = 8'h20;

  typedef struct packed {
    status_t    status;
    logic [6:0] length;
    logic       ready;
    logic [7:0] rchar;
  } line_result_t;

  phase_t       line_phase;
  logic [6:0]   char_count;
  logic [7:0]   char_store [LINE_CAPACITY];
  line_result_t results_due [$];
  int           fail_count = 0;

  initial begin
    errors  = 0;
    pending = 0;
  end

  // Applies one accepted item to the predicted line state and returns its result.
  task automatic predict_item(input logic [1:0] act, input logic [7:0] b,
                              input logic [5:0] idx, output line_result_t res);
    logic [7:0] c;
    res.status = ST_IGNORED;
    res.rchar  = 8'h00;
    case (act)
      ACT_RECV: begin
        if (line_phase == PH_HUNT) begin
          if (b == CH_DOLLAR) begin
            line_phase = PH_LINE;
            res.status = ST_START;
          end
        end else if (line_phase != PH_LINE) begin
          res.status = ST_REFUSED;
        end else if (b == CH_DOLLAR) begin
          char_count = '0;
          res.status = ST_RESTART;
        end else if (b == CH_CR || b == CH_LF) begin
          line_phase = PH_READY;
          res.status = ST_COMPLETE;
        end else if (b == CH_BS) begin
          // A backspace on an empty line leaves everything as it is.
          if (char_count != 0) begin
            char_count = char_count - 1'b1;
            res.status = ST_ERASED;
          end
        end else if (char_count >= LINE_CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          c = b;
          if (b >= CH_LOW_A && b <= CH_LOW_Z) begin
            c = b - CASE_OFFSET;
          end
          char_store[char_count[5:0]] = c;
          char_count = char_count + 1'b1;
          res.status = ST_STORED;
        end
      end
      ACT_CLEAR: begin
        char_count = '0;
        line_phase = PH_HUNT;
        res.status = ST_CLEARED;
      end
      ACT_READ: begin
        if (idx < char_count) begin
          res.rchar = char_store[idx];
        end
        res.status = ST_READ;
      end
      default: ;
    endcase
    res.length = char_count;
    res.ready  = (line_phase == PH_READY);
  endtask

  task automatic check_field(input string field, input logic [7:0] exp, input logic [7:0] got);
    if (got !== exp) begin
      $error("%s mismatch: expected %0d, actual %0d", field, exp, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    line_result_t due;
    line_result_t fresh;
    if (rst) begin
      line_phase = PH_HUNT;
      char_count = '0;
      results_due.delete();
    end else begin
      // The result leaving at this edge belongs to an earlier item, so compare before
      // predicting the item taken at the same edge.
      if (m_tvalid && m_tready) begin
        if (results_due.size() == 0) begin
          $error("result transfer with no expectation waiting, status %0d", m_tuser);
          fail_count++;
        end else begin
          due = results_due.pop_front();
          check_field("status", {4'b0, due.status}, {4'b0, m_tuser});
          check_field("line_length", {1'b0, due.length}, {1'b0, m_tdata[6:0]});
          check_field("line_ready", {7'b0, due.ready}, {7'b0, m_tdata[7]});
          check_field("read_char", due.rchar, m_tdata[15:8]);
        end
      end
      if (s_tvalid && s_tready) begin
        predict_item(s_tuser, s_tdata[7:0], s_tdata[13:8], fresh);
        results_due.push_back(fresh);
      end
    end
    errors  <= fail_count;
    pending <= results_due.size();
  end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// Top of the line receiver testbench: clock, reset, stimulus, receiver stalls and verdict.
// Depends on dflr_pkg, dollar_framed_line_receiver_unit and dflr_checker.

module tb;
  import dflr_pkg::*;

  localparam logic [1:0] ACT_SPARE     = 2'd3;
  localparam int         RANDOM_ITEMS  = 1000;
  localparam int         DIRECTED      = 25;
  localparam int         STALL_LIMIT   = 5000;
  localparam int         PRESSURE_HOLD = 80;
  localparam int         DRAIN_CYCLES  = 4;

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata  = '0;
  logic [1:0]  s_tuser  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic [3:0]  m_tuser;

  int errors;
  int pending;
  int burst_left  = 0;
  int sent_count  = 0;
  int idle_cycles = 0;

  dollar_framed_line_receiver_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  dflr_checker chk (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .errors   (errors),
    .pending  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Offers one item and returns once its transfer has happened. Bursts of random length
  // are usually separated by random idle gaps.
  task automatic send_item(input logic [1:0] act, input logic [7:0] b, input logic [5:0] idx);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {2'b00, idx, b};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
    if (act != ACT_SPARE) begin
      sent_count++;
    end
  endtask

  task automatic recv_byte(input logic [7:0] b);
    send_item(ACT_RECV, b, 6'($urandom_range(0, 63)));
  endtask

  task automatic read_at(input logic [5:0] idx);
    send_item(ACT_READ, 8'($urandom_range(0, 255)), idx);
  endtask

  task automatic clear_line();
    send_item(ACT_CLEAR, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)));
  endtask

  // Line content: mostly letters, then printable text, and in edited lines any byte at all.
  function automatic logic [7:0] body_char(input bit clean);
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      return 8'($urandom_range(CH_LOW_A, CH_LOW_Z));
    end else if (r < 80 || clean) begin
      return 8'($urandom_range(8'h25, 8'h7E));
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // One framed line: optional noise while hunting, the start byte, a body with optional
  // editing and reads, a terminator, a few items while the line is held, then usually a clear.
  task automatic send_line(input int body_len, input bit clean);
    int r;
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) recv_byte(8'($urandom_range(0, 255)));
    end
    recv_byte(CH_DOLLAR);
    for (int i = 0; i < body_len; i++) begin
      r = clean ? 99 : $urandom_range(0, 99);
      if (r < 8) begin
        recv_byte(CH_BS);
      end else if (r < 10) begin
        recv_byte(CH_DOLLAR);
      end else if (r < 15) begin
        read_at(6'($urandom_range(0, 7)));
      end else if (r < 20) begin
        read_at(6'($urandom_range(0, 63)));
      end else begin
        recv_byte(body_char(clean));
      end
    end
    recv_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
    repeat ($urandom_range(0, 4)) begin
      if ($urandom_range(0, 1)) begin
        recv_byte(8'($urandom_range(0, 255)));
      end else begin
        read_at(6'($urandom_range(0, 63)));
      end
    end
    if ($urandom_range(0, 9) != 0) begin
      clear_line();
    end
  endtask

  // Receiver: segments of steady acceptance, random stalls and holds. One early segment is a
  // long hold so that the output register fills and the input side backs up.
  initial begin
    int seg;
    int mode;
    int len;
    seg = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      mode = $urandom_range(0, 9);
      len  = $urandom_range(10, 60);
      if (seg == 4) begin
        repeat (PRESSURE_HOLD) begin
          m_tready <= 1'b0;
          @(posedge clk);
        end
      end else if (mode == 0) begin
        repeat ($urandom_range(15, 35)) begin
          m_tready <= 1'b0;
          @(posedge clk);
        end
      end else if (mode < 4) begin
        repeat (len) begin
          m_tready <= 1'b1;
          @(posedge clk);
        end
      end else if (mode < 7) begin
        repeat (len) begin
          m_tready <= ($urandom_range(0, 1) == 0);
          @(posedge clk);
        end
      end else begin
        repeat (len) begin
          m_tready <= ($urandom_range(0, 3) != 0);
          @(posedge clk);
        end
      end
      seg++;
    end
  end

  // Watchdog: ends the run if no transfer happens on either side for too long.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    int r;
    int len;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part: bytes while hunting, the case boundaries, editing, reads inside and
    // past the line, restart, both terminators, refusal while held and clears.
    recv_byte(8'h41);
    send_item(ACT_SPARE, 8'hFF, 6'h3F);
    recv_byte(CH_DOLLAR);
    recv_byte(CH_LOW_A);
    recv_byte(CH_LOW_Z);
    recv_byte(8'h60);
    recv_byte(8'h7B);
    recv_byte(8'hFF);
    recv_byte(8'h00);
    recv_byte(CH_BS);
    read_at(6'd0);
    read_at(6'd3);
    read_at(6'd63);
    recv_byte(CH_DOLLAR);
    recv_byte(CH_BS);
    recv_byte(8'h6D);
    recv_byte(CH_CR);
    recv_byte(8'h78);
    read_at(6'd0);
    clear_line();
    read_at(6'd0);
    recv_byte(CH_DOLLAR);
    recv_byte(CH_LF);
    recv_byte(CH_DOLLAR);
    clear_line();

    // Random part. The first line overruns the store so that dropping is reached early.
    send_line(72, 1'b1);
    while (sent_count < DIRECTED + RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        repeat ($urandom_range(1, 10)) begin
          send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                    6'($urandom_range(0, 63)));
        end
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          len = $urandom_range(0, 12);
        end else if (r < 88) begin
          len = $urandom_range(13, 40);
        end else begin
          len = $urandom_range(60, 80);
        end
        send_line(len, (len >= 60) && ($urandom_range(0, 1) == 0));
      end
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
